// File: hw/rtl/msd_pkg.sv
// Shared types and constants for the multichannel sample delay unit.
// No dependencies; the delay calculator, the top level and both testbench files import this package.
`default_nettype none

package msd_pkg;

  localparam int CHANNELS    = 16;
  localparam int MAX_DELAY   = 1024;
  localparam int SAMPLE_BITS = 24;

  localparam int CHAN_W     = $clog2(CHANNELS);
  localparam int SLOT_W     = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int DELAY_W    = $clog2(MAX_DELAY + 1);
  localparam int RING_DEPTH = CHANNELS * MAX_DELAY;
  localparam int RING_AW    = $clog2(RING_DEPTH);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_DELAY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_DELAY     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTERLEAVE    = 3'd4;

  typedef struct packed {
    logic                   delay_mode;
    logic signed [19:0]     start_delay;
    logic signed [19:0]     end_delay;
    logic [4:0]             channel_count;
    logic [2:0]             interleave_level;
  } cfg_t;

  typedef struct packed {
    logic [CHAN_W-1:0]             channel_index;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          restart;
  } item_t;

  typedef struct packed {
    logic [CHAN_W-1:0]             channel_out;
    logic signed [SAMPLE_BITS-1:0] sample_out;
  } result_t;

  // Request from the sequencer to the delay calculator.
  typedef struct packed {
    logic              start;
    logic [CHAN_W-1:0] chan;
  } calc_req_t;

  // Answer of the delay calculator, delay in whole samples.
  typedef struct packed {
    logic               done;
    logic [DELAY_W-1:0] delay;
  } calc_rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/msd_ring_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Standalone; holds the per-channel sample history rings.
`default_nettype none

module msd_ring_ram #(
  parameter int DEPTH = 16384,
  parameter int WIDTH = 24
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/msd_delay_calc.sv
// Per-item delay calculator: group/interleave decode, linear spread with a
// bit-serial divider, rounding and clamping to whole samples. Uses msd_pkg.
`default_nettype none

module msd_delay_calc import msd_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cfg_t      cfg,
  input  wire calc_req_t req,
  output      calc_rsp_t rsp
);

  localparam int DIFF_W = 21;
  localparam int PROD_W = 26;
  localparam int MAG_W  = 24;
  localparam int SUM_W  = 27;
  localparam int CNT_W  = $clog2(MAG_W);

  localparam logic [2:0] C_IDLE  = 3'd0;
  localparam logic [2:0] C_PREP  = 3'd1;
  localparam logic [2:0] C_MUL   = 3'd2;
  localparam logic [2:0] C_DIV   = 3'd3;
  localparam logic [2:0] C_SUM   = 3'd4;
  localparam logic [2:0] C_CLAMP = 3'd5;

  typedef struct packed {
    logic [4:0] quo;
    logic [2:0] rem;
  } divmod_t;

  // Narrow restoring division, one quotient bit per step.
  function automatic divmod_t divmod5(input logic [4:0] n, input logic [2:0] d);
    divmod_t    res;
    logic [3:0] r;
    r = '0;
    res.quo = '0;
    for (int i = 4; i >= 0; i--) begin
      r = {r[2:0], n[i]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        res.quo[i] = 1'b1;
      end
    end
    res.rem = r[2:0];
    return res;
  endfunction

  logic [2:0]               state;
  logic [CHAN_W-1:0]        chan;
  logic [3:0]               grp;
  logic                     delayed;
  logic                     linear;
  logic [4:0]               divisor;
  logic signed [DIFF_W-1:0] diff;
  logic                     neg;
  logic [MAG_W-1:0]         mag;
  logic [5:0]               rem;
  logic [CNT_W-1:0]         cnt;
  logic signed [SUM_W-1:0]  sum;

  logic [2:0]               il;
  divmod_t                  cdiv;
  divmod_t                  gdiv;
  logic                     ini_pos;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]        prod_abs;
  logic [5:0]               trial;
  logic signed [SUM_W-1:0]  quot;
  logic [SUM_W-1:0]         sum_abs;
  logic [SUM_W-9:0]         whole;
  logic [DELAY_W-1:0]       delay_c;

  assign il      = (cfg.interleave_level == 3'd0) ? 3'd1 : cfg.interleave_level;
  assign cdiv    = divmod5({1'b0, chan}, il);
  assign gdiv    = divmod5(cfg.channel_count, il);
  assign ini_pos = !cfg.start_delay[19] && (cfg.start_delay != '0);

  assign prod     = PROD_W'(diff) * PROD_W'($signed({1'b0, grp}));
  assign prod_abs = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
  assign trial    = {rem[4:0], mag[MAG_W-1]};

  assign quot    = neg ? -SUM_W'($signed({1'b0, mag})) : SUM_W'($signed({1'b0, mag}));
  assign sum_abs = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign whole   = sum_abs[SUM_W-1:8];
  assign delay_c = !delayed ? '0 :
                   (whole > (SUM_W-8)'(MAX_DELAY)) ? DELAY_W'(MAX_DELAY) :
                   DELAY_W'(whole);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= C_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= (state == C_CLAMP);
      case (state)
        C_IDLE: begin
          if (req.start) begin
            state <= C_PREP;
          end
        end
        C_PREP:  state <= C_MUL;
        C_MUL:   state <= linear ? C_DIV : C_SUM;
        C_DIV: begin
          if (cnt == '0) begin
            state <= C_SUM;
          end
        end
        C_SUM:   state <= C_CLAMP;
        C_CLAMP: begin
          rsp.delay <= delay_c;
          state     <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      C_IDLE: begin
        chan <= req.chan;
      end
      C_PREP: begin
        grp     <= cdiv.quo[3:0];
        delayed <= (il == 3'd1) || (ini_pos ? (cdiv.rem == 3'd1) : (cdiv.rem == 3'd0));
        linear  <= cfg.delay_mode && (gdiv.quo >= 5'd2);
        divisor <= gdiv.quo - 5'd1;
        diff    <= DIFF_W'(cfg.end_delay) - DIFF_W'(cfg.start_delay);
      end
      C_MUL: begin
        neg <= prod[PROD_W-1];
        mag <= linear ? prod_abs[MAG_W-1:0] : '0;
        rem <= '0;
        cnt <= CNT_W'(MAG_W - 1);
      end
      C_DIV: begin
        if (trial >= {1'b0, divisor}) begin
          rem <= trial - {1'b0, divisor};
          mag <= {mag[MAG_W-2:0], 1'b1};
        end else begin
          rem <= trial;
          mag <= {mag[MAG_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
      end
      C_SUM: begin
        sum <= SUM_W'(cfg.start_delay) + quot + SUM_W'(128);
      end
      default: begin
      end
    endcase
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> state == C_IDLE)
    else $error("delay request while the calculator is busy");

  a_done_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> rsp.delay <= DELAY_W'(MAX_DELAY))
    else $error("delay exceeds the clamp limit");

  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    state == C_DIV |=> state == C_DIV || state == C_SUM)
    else $error("divider left its loop early");

endmodule

`default_nettype wire

// File: hw/rtl/multichannel_sample_delay_unit.sv
// Each item passes through the delay calculator and then the ring read and finish steps; in linear mode
// with two or more channel groups the calculator also runs its 24-step serial divider.
// One item is in flight at a time; the input opens again in the cycle after the
// result is loaded, and a result held by result_stall delays the next load.
// Reset clears the sequencer, the configuration registers and every channel's sample count
// and ring position; the sample history RAM is not cleared and needs no clearing pass.
`default_nettype none

module multichannel_sample_delay_unit import msd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  item_valid,
  output      logic                  item_stall,
  input  wire item_t                 item,
  output      logic                  result_valid,
  input  wire logic                  result_stall,
  output      result_t               result
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  cfg_t      cfg;
  calc_req_t calc_req;
  calc_rsp_t calc_rsp;

  logic [1:0]                    state;
  logic [CHAN_W-1:0]             cur_chan;
  logic signed [SAMPLE_BITS-1:0] cur_sample;
  logic [DELAY_W-1:0]            cur_seen;
  logic [SLOT_W-1:0]             cur_slot;
  logic [DELAY_W-1:0]            cur_delay;

  logic [DELAY_W-1:0] seen_mem [CHANNELS];
  logic [SLOT_W-1:0]  slot_mem [CHANNELS];

  logic                   accept;
  logic                   load;
  logic [DELAY_W-1:0]     slot_ext;
  logic [DELAY_W-1:0]     rslot_full;
  logic [RING_AW-1:0]     base;
  logic                   ring_we;
  logic                   ring_re;
  logic [RING_AW-1:0]     ring_waddr;
  logic [RING_AW-1:0]     ring_raddr;
  logic [SAMPLE_BITS-1:0] ring_rdata;
  logic [SAMPLE_BITS-1:0] picked;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign load       = (state == S_FIN) && (!result_valid || !result_stall);

  assign calc_req.start = accept;
  assign calc_req.chan  = item.channel_index;

  // Read slot is the write slot moved back by the delay, modulo the ring length.
  assign slot_ext   = DELAY_W'(cur_slot);
  assign rslot_full = (slot_ext >= cur_delay) ? slot_ext - cur_delay
                                              : slot_ext + DELAY_W'(MAX_DELAY) - cur_delay;
  assign base       = RING_AW'(cur_chan) * RING_AW'(MAX_DELAY);
  assign ring_raddr = base + RING_AW'(rslot_full[SLOT_W-1:0]);
  assign ring_waddr = base + RING_AW'(cur_slot);
  assign ring_re    = (state == S_READ);
  assign ring_we    = load;

  // The read finishes in S_READ, before the write in S_FIN, so a full-length
  // delay still sees the old contents of the slot that is about to be overwritten.
  assign picked = (cur_delay == '0)       ? cur_sample :
                  (cur_seen >= cur_delay) ? ring_rdata : '0;

  msd_delay_calc u_calc (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .req (calc_req),
    .rsp (calc_rsp)
  );

  msd_ring_ram #(
    .DEPTH (RING_DEPTH),
    .WIDTH (SAMPLE_BITS)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (cur_sample),
    .re    (ring_re),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delay_mode       <= 1'b0;
      cfg.start_delay      <= '0;
      cfg.end_delay        <= '0;
      cfg.channel_count    <= 5'd1;
      cfg.interleave_level <= 3'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DELAY_MODE:    cfg.delay_mode       <= cfg_data[0];
        REG_START_DELAY:   cfg.start_delay      <= cfg_data[19:0];
        REG_END_DELAY:     cfg.end_delay        <= cfg_data[19:0];
        REG_CHANNEL_COUNT: cfg.channel_count    <= cfg_data[4:0];
        REG_INTERLEAVE:    cfg.interleave_level <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        seen_mem[i] <= '0;
        slot_mem[i] <= '0;
      end
    end else begin
      if (load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_CALC;
          end
        end
        S_CALC: begin
          if (calc_rsp.done) begin
            state <= S_READ;
          end
        end
        S_READ: state <= S_FIN;
        S_FIN: begin
          if (load) begin
            seen_mem[cur_chan] <= (cur_seen < DELAY_W'(MAX_DELAY)) ? cur_seen + 1'b1
                                                                   : cur_seen;
            slot_mem[cur_chan] <= (cur_slot == SLOT_W'(MAX_DELAY - 1)) ? '0
                                                                       : cur_slot + 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_chan   <= item.channel_index;
      cur_sample <= item.sample_in;
      cur_seen   <= item.restart ? '0 : seen_mem[item.channel_index];
      cur_slot   <= slot_mem[item.channel_index];
    end
    if (calc_rsp.done) begin
      cur_delay <= calc_rsp.delay;
    end
    if (load) begin
      result.channel_out <= cur_chan;
      result.sample_out  <= picked;
    end
  end

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_FIN)
    else $error("result appeared outside the finish step");

  a_done_in_calc: assert property (@(posedge clk) disable iff (rst)
    calc_rsp.done |-> state == S_CALC)
    else $error("delay answer arrived while the sequencer was not waiting");

  a_write_gives_result: assert property (@(posedge clk) disable iff (rst)
    ring_we |=> result_valid && state == S_IDLE)
    else $error("ring write without a loaded result");

endmodule

`default_nettype wire

// File: dv/delay_line_checker.sv
// Checker for the multichannel sample delay unit: watches the configuration port and both
// channels, keeps its own copy of the per-channel delay lines and compares every result.
// Depends on msd_pkg for the payload types, register indexes and size constants.
module delay_line_checker import msd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  item_valid,
  input  logic                  item_stall,
  input  item_t                 item,
  input  logic                  result_valid,
  input  logic                  result_stall,
  input  result_t               result,
  output int                    failures,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic               mode_q;
  logic signed [19:0] initial_q;
  logic signed [19:0] final_q;
  logic [4:0]         count_q;
  logic [2:0]         interleave_q;

  logic [SAMPLE_BITS-1:0] history [CHANNELS][MAX_DELAY];
  int                     seen [CHANNELS];
  int                     slot [CHANNELS];

  result_t delayed_samples_due [$];

  initial begin
    failures = 0;
    pending  = 0;
  end

  task automatic note_mismatch(string msg);
    // Keep the log short on a badly broken build; every mismatch is still counted.
    if (failures < 100) $display("%0t ns mismatch: %s", $realtime, msg);
    failures++;
  endtask

  // Delay of one channel in whole samples under the current register settings.
  function automatic int channel_delay(logic [CHAN_W-1:0] ch);
    int unsigned il;
    longint      ini;
    longint      fin;
    longint      d;
    longint      groups;
    longint      g;
    il  = (interleave_q == 3'd0) ? 1 : int'(interleave_q);
    ini = longint'(initial_q);
    fin = longint'(final_q);
    if (il != 1) begin
      if (ini > 0) begin
        if (int'(ch) % il != 1) return 0;
      end else if (int'(ch) % il != 0) begin
        return 0;
      end
    end
    d = ini;
    if (mode_q) begin
      groups = longint'(int'(count_q) / il);
      if (groups >= 2) begin
        g = longint'(int'(ch) / il);
        d = ini + ((fin - ini) * g) / (groups - 1);
      end
    end
    d = d + 128;
    if (d < 0) d = -d;
    d = d >> 8;
    if (d > MAX_DELAY) d = MAX_DELAY;
    return int'(d);
  endfunction

  function automatic result_t predict_delayed_sample(item_t it);
    result_t          r;
    logic [CHAN_W-1:0] ch;
    int               dl;
    int               ws;
    ch = it.channel_index;
    if (it.restart) seen[ch] = 0;
    dl = channel_delay(ch);
    ws = slot[ch];
    r.channel_out = ch;
    if (dl == 0) r.sample_out = it.sample_in;
    else if (seen[ch] >= dl) r.sample_out = history[ch][(ws + MAX_DELAY - dl) % MAX_DELAY];
    else r.sample_out = '0;
    history[ch][ws] = it.sample_in;
    slot[ch] = (ws + 1) % MAX_DELAY;
    if (seen[ch] < MAX_DELAY) seen[ch]++;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      mode_q       = 1'b0;
      initial_q    = '0;
      final_q      = '0;
      count_q      = 5'd1;
      interleave_q = 3'd1;
      for (int c = 0; c < CHANNELS; c++) begin
        seen[c] = 0;
        slot[c] = 0;
      end
      delayed_samples_due.delete();
    end else begin
      // Results are matched before this edge's input transfer is queued, so a result can
      // never be paired with an item taken at the same edge.
      if (result_valid && !result_stall) begin
        if (delayed_samples_due.size() == 0) begin
          note_mismatch($sformatf("result with nothing outstanding: chan %0d sample %0d",
                                  result.channel_out, result.sample_out));
        end else begin
          want = delayed_samples_due.pop_front();
          if (result.channel_out !== want.channel_out)
            note_mismatch($sformatf("channel_out %0d, predicted %0d",
                                    result.channel_out, want.channel_out));
          if (result.sample_out !== want.sample_out)
            note_mismatch($sformatf("chan %0d sample_out %0d, predicted %0d",
                                    want.channel_out, result.sample_out, want.sample_out));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_DELAY_MODE:    mode_q       = cfg_data[0];
          REG_START_DELAY:   initial_q    = cfg_data[19:0];
          REG_END_DELAY:     final_q      = cfg_data[19:0];
          REG_CHANNEL_COUNT: count_q      = cfg_data[4:0];
          REG_INTERLEAVE:    interleave_q = cfg_data[2:0];
          default: ;
        endcase
      end
      if (item_valid && !item_stall)
        delayed_samples_due.push_back(predict_delayed_sample(item));
    end
    pending <= delayed_samples_due.size();
  end

endmodule

// File: dv/multichannel_sample_delay_unit_tb.sv
// Top of the multichannel sample delay unit testbench: clock, reset, register programming,
// sample stimulus with random gaps and stalls, and the final verdict.
// Depends on msd_pkg, the unit under test and delay_line_checker.
module multichannel_sample_delay_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import msd_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int LONG_HOLD   = 600;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_DELAY_MODE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  item_t                 item = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;
  int                    failures;
  int                    pending;
  int                    quiet = 0;
  bit                    steady = 1'b0;

  multichannel_sample_delay_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  delay_line_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .failures     (failures),
    .pending      (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("multichannel_sample_delay_unit_tb NOT OK");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Result side: a random hold-off before each transfer, calm stretches now and then, and one
  // long hold-off so the unit backs up and stalls the sample input.
  initial begin : drain
    int hold;
    int taken;
    bit calm;
    taken = 0;
    calm  = 1'b0;
    forever begin
      if (taken % 40 == 0) calm = ($urandom_range(3, 0) == 0);
      hold = calm ? 0 : $urandom_range(14, 0);
      if (taken == 400) hold = LONG_HOLD;
      for (int c = 0; c < hold; c++) begin
        @(negedge clk);
        result_stall = 1'b1;
      end
      @(negedge clk);
      result_stall = 1'b0;
      do @(posedge clk); while (!result_valid);
      taken++;
    end
  end

  function automatic item_t sample_of(int ch, logic [SAMPLE_BITS-1:0] s, bit restart);
    item_t x;
    x.channel_index = CHAN_W'(ch);
    x.sample_in     = s;
    x.restart       = restart;
    return x;
  endfunction

  function automatic item_t random_sample(int lo, int hi, int hot_pct, int restart_odds);
    item_t x;
    if ($urandom_range(99, 0) < hot_pct) x.channel_index = CHAN_W'($urandom_range(hi, lo));
    else x.channel_index = CHAN_W'($urandom_range(CHANNELS - 1, 0));
    case ($urandom_range(15, 0))
      0:       x.sample_in = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      1:       x.sample_in = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      2:       x.sample_in = '0;
      3:       x.sample_in = '1;
      default: x.sample_in = SAMPLE_BITS'($urandom);
    endcase
    x.restart = (restart_odds != 0) && ($urandom_range(restart_odds - 1, 0) == 0);
    return x;
  endfunction

  // Offers one sample after a random gap, or none while steady, and returns at the edge that takes it.
  task automatic offer(item_t x);
    int gap;
    gap = steady ? 0 : $urandom_range(14, 0);
    for (int c = 0; c < gap; c++) begin
      @(negedge clk);
      item_valid = 1'b0;
    end
    @(negedge clk);
    item_valid = 1'b1;
    item       = x;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
  endtask

  // Registers change only once every predicted result has been taken.
  task automatic program_delay(bit mode, int ini, int fin, int count, int il);
    @(negedge clk);
    item_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    write_reg(REG_DELAY_MODE, CFG_DATA_W'(mode));
    write_reg(REG_START_DELAY, CFG_DATA_W'(ini));
    write_reg(REG_END_DELAY, CFG_DATA_W'(fin));
    write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'(count));
    write_reg(REG_INTERLEAVE, CFG_DATA_W'(il));
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic run_phase(bit mode, int ini, int fin, int count, int il, int n,
                           int lo, int hi, int hot_pct, int restart_odds);
    program_delay(mode, ini, fin, count, il);
    steady = ($urandom_range(3, 0) == 0);
    repeat (n) offer(random_sample(lo, hi, hot_pct, restart_odds));
  endtask

  // Short phase on a few busy channels so that short delays fill and start returning history.
  task automatic short_phase(bit mode, int ini, int fin, int count, int il);
    int lo;
    lo = $urandom_range(CHANNELS - 4, 0);
    run_phase(mode, ini, fin, count, il, 55, lo, lo + 3, 75, 25);
  endtask

  initial begin : stimulus
    int ini;
    int fin;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset settings give a zero delay: samples pass straight through.
    offer(sample_of(0, 24'h7FFFFF, 1'b1));
    offer(sample_of(15, 24'h800000, 1'b0));
    offer(sample_of(0, 24'h000000, 1'b0));
    offer(sample_of(15, 24'hFFFFFF, 1'b1));
    offer(sample_of(5, 24'h555555, 1'b0));
    offer(sample_of(10, 24'hAAAAAA, 1'b0));

    // Two-sample delay: zeros first, then history; a restart brings the zeros back.
    program_delay(1'b0, 512, 0, 16, 1);
    offer(sample_of(3, 24'd100, 1'b1));
    offer(sample_of(3, 24'd200, 1'b0));
    offer(sample_of(3, 24'd300, 1'b0));
    offer(sample_of(3, 24'd400, 1'b0));
    offer(sample_of(3, 24'd500, 1'b1));
    offer(sample_of(3, 24'd600, 1'b0));
    offer(sample_of(3, 24'd700, 1'b0));

    // Linear mode with a single group and interleave zero falls back to the initial delay.
    program_delay(1'b1, 256, 8000, 1, 0);
    offer(sample_of(2, 24'd11, 1'b1));
    offer(sample_of(2, 24'd22, 1'b0));
    offer(sample_of(2, 24'd33, 1'b0));
    offer(sample_of(12, 24'd44, 1'b1));
    offer(sample_of(12, 24'd55, 1'b0));

    short_phase(1'b0, 128, 0, 16, 1);
    short_phase(1'b0, 1000, 0, 16, 2);

    // One channel runs well past the deepest delay: the ring wraps and the count saturates.
    run_phase(1'b0, -262144, 0, 16, 1, 1150, 7, 7, 92, 0);

    short_phase(1'b0, -700, 0, 16, 2);
    short_phase(1'b1, 256, 2560, 16, 1);
    short_phase(1'b1, -512, 5120, 8, 2);
    short_phase(1'b1, 262144, -262144, 16, 4);
    short_phase(1'b1, 384, 4000, 9, 3);
    // Channels past the channel count take their group from the index.
    short_phase(1'b1, 300, -3000, 2, 1);
    short_phase(1'b1, 640, 6000, 16, 0);
    short_phase(1'b0, -385, 0, 16, 1);
    short_phase(1'b1, -262144, 262144, 2, 1);

    repeat (3) begin
      ini = $urandom_range(1, 0) ? int'($urandom_range(6000, 0)) - 3000
                                 : int'($urandom_range(524288, 0)) - 262144;
      fin = $urandom_range(1, 0) ? int'($urandom_range(6000, 0)) - 3000
                                 : int'($urandom_range(524288, 0)) - 262144;
      short_phase(1'($urandom_range(1, 0)), ini, fin, $urandom_range(16, 1),
                  $urandom_range(4, 1));
    end

    @(negedge clk);
    item_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (failures == 0) begin
      $display("multichannel_sample_delay_unit_tb OK");
    end else begin
      $display("multichannel_sample_delay_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
